>>> rtl/polyphonic_voice_allocator_macros.svh
// Assertion macros for the polyphonic voice allocator.
`ifndef POLYPHONIC_VOICE_ALLOCATOR_MACROS_SVH
`define POLYPHONIC_VOICE_ALLOCATOR_MACROS_SVH

`ifndef SYNTHESIS
// Check a property on every clock edge outside reset.
`define PVA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Check that a condition in one cycle leads to another in the next cycle.
`define PVA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define PVA_ASSERT(lbl, prop, msg)
`define PVA_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

>>> rtl/pva_pkg.sv
// Shared constants, types and codes of the polyphonic voice allocator.
`timescale 1ns / 1ps
`default_nettype none
package pva_pkg;

  localparam int VOICES   = 8;
  localparam int AGE_BITS = 32;
  localparam int VOICE_W  = $clog2(VOICES);
  localparam int PITCH_W  = 7;
  localparam int VEL_W    = 7;

  localparam logic [1:0] OP_NOTE_ON    = 2'd0;
  localparam logic [1:0] OP_NOTE_OFF   = 2'd1;
  localparam logic [1:0] OP_VOICE_IDLE = 2'd2;

  typedef struct packed {
    logic [1:0]         operation;
    logic [PITCH_W-1:0] pitch;
    logic [VEL_W-1:0]   velocity;
    logic [2:0]         idle_voice;
  } item_t;

  typedef struct packed {
    logic [2:0] assigned_voice;
    logic       stolen;
    logic [7:0] release_mask;
  } result_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COMMIT
  } state_e;

  // One voice entry as seen by the scan.
  typedef struct packed {
    logic                active;
    logic [PITCH_W-1:0]  pitch;
    logic [AGE_BITS-1:0] age;
  } voice_rd_t;

  // Update applied to the voice file at the end of a transaction.
  typedef struct packed {
    logic               note_on;
    logic               idle;
    logic [VOICE_W-1:0] idx;
    logic [PITCH_W-1:0] pitch;
  } voice_wr_t;

endpackage
`default_nettype wire

>>> rtl/polyphonic_voice_allocator.sv
// Top level of the polyphonic voice allocator with oldest-voice stealing.
//
//   channel   handshake          payload            direction
//   item      start / busy       item_i   (item_t)   in
//   result    done_o (strobe)    result_o (result_t) out
//
// Note on and note off scan the voices one per cycle through the shared age/pitch
// compare, then pass through the commit state and the result register; voice idle and
// the unused code go from the accepting edge straight to the commit state, then the
// result register. busy is high from the accepting edge through the commit
// cycle; a new transaction may be accepted while the previous result is on the ports.
// The result shows for one cycle and cannot be held off. Reset clears all voices.
`timescale 1ns / 1ps
`default_nettype none
`include "polyphonic_voice_allocator_macros.svh"
module polyphonic_voice_allocator (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       start,
  output logic            busy,
  input  wire pva_pkg::item_t item_i,
  output logic            done_o,
  output pva_pkg::result_t result_o
);

  logic [pva_pkg::VOICE_W-1:0] rd_idx;
  pva_pkg::voice_rd_t          rd;
  pva_pkg::voice_wr_t          wr;
  logic                        res_valid;
  pva_pkg::result_t            res;
  logic                        done_q;
  pva_pkg::result_t            result_q;

  pva_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .item_i      (item_i),
    .rd_idx_o    (rd_idx),
    .rd_i        (rd),
    .wr_o        (wr),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  pva_voice_file u_voice_file (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_idx_i (rd_idx),
    .rd_o     (rd),
    .wr_i     (wr)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      result_q <= res;
    end
  end

  assign done_o   = done_q;
  assign result_o = result_q;

  `PVA_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted transaction did not raise busy")
  `PVA_ASSERT_NEXT(a_single_strobe, done_o, !done_o, "result strobe lasted two cycles")
  `PVA_ASSERT(a_done_on_finish, $fell(busy) |-> done_o, "busy dropped without a result")
  `PVA_ASSERT(a_result_kind, done_o |-> !((result_o.stolen || result_o.assigned_voice != 3'd0) && result_o.release_mask != 8'd0), "note on and note off fields both set")

endmodule
`default_nettype wire

>>> rtl/pva_voice_file.sv
// Voice state: active flags, pitch and age stamps, and the saturating age counter.
`timescale 1ns / 1ps
`default_nettype none
module pva_voice_file (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic [pva_pkg::VOICE_W-1:0]   rd_idx_i,
  output pva_pkg::voice_rd_t                 rd_o,
  input  wire pva_pkg::voice_wr_t            wr_i
);

  logic [pva_pkg::VOICES-1:0]   active_q;
  logic [pva_pkg::PITCH_W-1:0]  pitch_q [pva_pkg::VOICES];
  logic [pva_pkg::AGE_BITS-1:0] age_q   [pva_pkg::VOICES];
  logic [pva_pkg::AGE_BITS-1:0] age_cnt_q, age_cnt_d;

  // Saturate at all ones.
  assign age_cnt_d = (&age_cnt_q) ? age_cnt_q : age_cnt_q + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q  <= '0;
      age_cnt_q <= '0;
    end else begin
      if (wr_i.note_on) begin
        active_q[wr_i.idx] <= 1'b1;
        age_cnt_q          <= age_cnt_d;
      end else if (wr_i.idle) begin
        active_q[wr_i.idx] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.note_on) begin
      pitch_q[wr_i.idx] <= wr_i.pitch;
      age_q[wr_i.idx]   <= age_cnt_d;
    end
  end

  // An inactive voice reads with age zero.
  always_comb begin
    rd_o.active = active_q[rd_idx_i];
    rd_o.pitch  = pitch_q[rd_idx_i];
    rd_o.age    = active_q[rd_idx_i] ? age_q[rd_idx_i] : '0;
  end

endmodule
`default_nettype wire

>>> rtl/pva_seq.sv
// Sequencer: walks the voices one per cycle through a shared compare unit, then commits.
`timescale 1ns / 1ps
`default_nettype none
module pva_seq (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start,
  output logic                               busy,
  input  wire pva_pkg::item_t                item_i,
  output logic [pva_pkg::VOICE_W-1:0]        rd_idx_o,
  input  wire pva_pkg::voice_rd_t            rd_i,
  output pva_pkg::voice_wr_t                 wr_o,
  output logic                               res_valid_o,
  output pva_pkg::result_t                   res_o
);

  localparam logic [pva_pkg::VOICE_W-1:0] LAST = pva_pkg::VOICE_W'(pva_pkg::VOICES - 1);

  pva_pkg::state_e                state_q, state_d;
  pva_pkg::item_t                 item_q, item_d;
  logic [pva_pkg::VOICE_W-1:0]    cnt_q, cnt_d;
  logic                           free_found_q, free_found_d;
  logic [pva_pkg::VOICE_W-1:0]    free_idx_q, free_idx_d;
  logic [pva_pkg::VOICE_W-1:0]    best_idx_q, best_idx_d;
  logic [pva_pkg::AGE_BITS-1:0]   best_age_q, best_age_d;
  logic [pva_pkg::VOICES-1:0]     mask_q, mask_d;
  logic                           age_lower;
  logic                           pitch_hit;
  logic [pva_pkg::VOICE_W-1:0]    target;

  // Shared compare unit, fed by the voice under scan.
  assign age_lower = rd_i.age < best_age_q;
  assign pitch_hit = rd_i.active && (rd_i.pitch == item_q.pitch);
  assign target    = free_found_q ? free_idx_q : best_idx_q;

  assign busy     = (state_q != pva_pkg::ST_IDLE);
  assign rd_idx_o = cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pva_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q       <= item_d;
    cnt_q        <= cnt_d;
    free_found_q <= free_found_d;
    free_idx_q   <= free_idx_d;
    best_idx_q   <= best_idx_d;
    best_age_q   <= best_age_d;
    mask_q       <= mask_d;
  end

  always_comb begin
    state_d      = state_q;
    item_d       = item_q;
    cnt_d        = cnt_q;
    free_found_d = free_found_q;
    free_idx_d   = free_idx_q;
    best_idx_d   = best_idx_q;
    best_age_d   = best_age_q;
    mask_d       = mask_q;
    wr_o         = '0;
    res_valid_o  = 1'b0;
    res_o        = '0;

    unique case (state_q)
      pva_pkg::ST_IDLE: begin
        if (start) begin
          item_d       = item_i;
          cnt_d        = '0;
          free_found_d = 1'b0;
          mask_d       = '0;
          if (item_i.operation == pva_pkg::OP_NOTE_ON ||
              item_i.operation == pva_pkg::OP_NOTE_OFF) begin
            state_d = pva_pkg::ST_SCAN;
          end else begin
            state_d = pva_pkg::ST_COMMIT;
          end
        end
      end
      pva_pkg::ST_SCAN: begin
        if (!rd_i.active && !free_found_q) begin
          free_found_d = 1'b1;
          free_idx_d   = cnt_q;
        end
        // First voice seeds the minimum; later ones replace it only when strictly older.
        if (cnt_q == '0 || age_lower) begin
          best_age_d = rd_i.age;
          best_idx_d = cnt_q;
        end
        if (pitch_hit) begin
          mask_d[cnt_q] = 1'b1;
        end
        if (cnt_q == LAST) begin
          state_d = pva_pkg::ST_COMMIT;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      pva_pkg::ST_COMMIT: begin
        res_valid_o = 1'b1;
        state_d     = pva_pkg::ST_IDLE;
        case (item_q.operation)
          pva_pkg::OP_NOTE_ON: begin
            if (item_q.velocity != '0) begin
              wr_o.note_on       = 1'b1;
              wr_o.idx           = target;
              wr_o.pitch         = item_q.pitch;
              res_o.assigned_voice = 3'(target);
              res_o.stolen       = !free_found_q;
            end else begin
              res_o.release_mask = 8'(mask_q);
            end
          end
          pva_pkg::OP_NOTE_OFF: begin
            res_o.release_mask = 8'(mask_q);
          end
          pva_pkg::OP_VOICE_IDLE: begin
            if (32'(item_q.idle_voice) < pva_pkg::VOICES) begin
              wr_o.idle = 1'b1;
              wr_o.idx  = pva_pkg::VOICE_W'(item_q.idle_voice);
            end
          end
          default: ;
        endcase
      end
      default: state_d = pva_pkg::ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire
